[rtl/rbba_pkg.sv]
package rbba_pkg;

  localparam int REG_W     = 13;
  localparam int BLK_W     = 12;
  localparam int OP_W      = 2;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam int NUM_BLOCKS_DEF = 4096;
  localparam int WORD_BITS_DEF  = 64;

  localparam logic [REG_W-1:0] TOTAL_BLOCKS_RST = 13'd2048;
  localparam logic [REG_W-1:0] META_START_RST   = 13'd2;
  localparam logic [REG_W-1:0] DATA_BASE_RST    = 13'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_BLOCKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_META_START   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE    = 2'd2;

  localparam logic [OP_W-1:0] OP_ALLOC_META = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_DATA = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC_ANY  = 2'd2;
  localparam logic [OP_W-1:0] OP_FREE       = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic [REG_W-1:0] total_blocks;
    logic [REG_W-1:0] meta_start;
    logic [REG_W-1:0] data_base;
  } cfg_regs_t;

endpackage

[rtl/region_bitmap_block_allocator.sv]
// First-fit block allocator over a used/free bitmap held in a single-port-read
// RAM of NUM_BLOCKS/WORD_BITS words. Raise start with in_op/in_block_number
// while busy is low; the item is taken on that edge. Exactly one result comes
// back on out_valid, held for one cycle only: the receiver cannot stall, so it
// must sample out_granted_block/out_status whenever out_valid is high. A free
// goes through S_PREP, S_DIV1 to S_DIV3 and S_FREE_WR; an allocation through
// S_PREP and S_DIV1 to S_DIV4, then S_SCAN reads one bitmap word a cycle (the
// RAM read port delivers one word a cycle) until a free block or the region end;
// an empty region or an out-of-range free ends in S_DIV1. After reset the bitmap
// is cleared one word a cycle with busy high; cfg writes are taken throughout.
module region_bitmap_block_allocator #(
  parameter int NUM_BLOCKS = rbba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = rbba_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [rbba_pkg::OP_W-1:0]       in_op,
  input  logic [rbba_pkg::BLK_W-1:0]      in_block_number,
  output logic                            out_valid,
  output logic [rbba_pkg::BLK_W-1:0]      out_granted_block,
  output logic [rbba_pkg::STAT_W-1:0]     out_status,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbba_pkg::REG_W-1:0]      cfg_data
);

  import rbba_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TOTAL_BLOCKS: cfg_nxt.total_blocks = cfg_data;
        CFG_META_START:   cfg_nxt.meta_start   = cfg_data;
        CFG_DATA_BASE:    cfg_nxt.data_base    = cfg_data;
        default:          cfg_nxt              = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.total_blocks <= TOTAL_BLOCKS_RST;
      cfg_r.meta_start   <= META_START_RST;
      cfg_r.data_base    <= DATA_BASE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  rbba_ctrl #(.NUM_BLOCKS(NUM_BLOCKS), .WORD_BITS(WORD_BITS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .start        (start),
    .busy         (busy),
    .op           (in_op),
    .block_number (in_block_number),
    .res_valid    (out_valid),
    .res_block    (out_granted_block),
    .res_status   (out_status)
  );

endmodule

[rtl/rbba_cdiv.sv]
module rbba_cdiv #(
  parameter int VW      = 13,
  parameter int DIVISOR = 64,
  parameter int OFF_W   = 6
) (
  input  logic             clk,
  input  logic [VW-1:0]    din,
  output logic [VW-1:0]    quo,
  output logic [OFF_W-1:0] rem
);

  localparam logic [VW-1:0] RECIP = VW'((64'd1 << VW) / DIVISOR);
  localparam logic [VW-1:0] DIV_V = VW'(DIVISOR);

  logic [2*VW-1:0] prod_r;
  logic [VW-1:0]   v_r;
  logic [VW-1:0]   q0;
  logic [VW-1:0]   r0;
  logic [VW-1:0]   q_r;
  logic [OFF_W-1:0] r_r;

  // reciprocal estimate is low by at most one
  always_ff @(posedge clk) begin
    prod_r <= (2*VW)'(din) * (2*VW)'(RECIP);
    v_r    <= din;
  end

  always_comb begin
    q0 = prod_r[2*VW-1:VW];
    r0 = v_r - VW'(q0 * DIV_V);
  end

  always_ff @(posedge clk) begin
    if (r0 >= DIV_V) begin
      q_r <= q0 + 1'b1;
      r_r <= OFF_W'(r0 - DIV_V);
    end else begin
      q_r <= q0;
      r_r <= OFF_W'(r0);
    end
  end

  assign quo = q_r;
  assign rem = r_r;

endmodule

[rtl/rbba_map.sv]
module rbba_map #(
  parameter int WORDS = 64,
  parameter int WB    = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [WB-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [WB-1:0] wr_data
);

  logic [WB-1:0] mem [WORDS];
  logic [WB-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/rbba_ctrl.sv]
module rbba_ctrl #(
  parameter int NUM_BLOCKS = rbba_pkg::NUM_BLOCKS_DEF,
  parameter int WORD_BITS  = rbba_pkg::WORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rbba_pkg::cfg_regs_t           cfg,
  input  logic                          start,
  output logic                          busy,
  input  logic [rbba_pkg::OP_W-1:0]     op,
  input  logic [rbba_pkg::BLK_W-1:0]    block_number,
  output logic                          res_valid,
  output logic [rbba_pkg::BLK_W-1:0]    res_block,
  output logic [rbba_pkg::STAT_W-1:0]   res_status
);

  import rbba_pkg::*;

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int VW        = (CNT_W > REG_W) ? CNT_W : REG_W;
  localparam int WI_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int OFF_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [VW-1:0]   NB_V   = VW'(NUM_BLOCKS);
  localparam logic [VW-1:0]   WB_V   = VW'(WORD_BITS);
  localparam logic [WI_W-1:0] LAST_W = WI_W'(MAP_WORDS - 1);

  typedef enum logic [8:0] {
    S_CLEAR   = 9'b000000001,
    S_IDLE    = 9'b000000010,
    S_PREP    = 9'b000000100,
    S_DIV1    = 9'b000001000,
    S_DIV2    = 9'b000010000,
    S_DIV3    = 9'b000100000,
    S_DIV4    = 9'b001000000,
    S_SCAN    = 9'b010000000,
    S_FREE_WR = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [BLK_W-1:0]    bno_r, bno_nxt;
  logic [VW-1:0]       tot_r, tot_nxt;
  logic [VW-1:0]       lo_r, lo_nxt;
  logic [VW-1:0]       hi_r, hi_nxt;
  logic [VW-1:0]       base_r, base_nxt;
  logic [WI_W-1:0]     w_r, w_nxt;
  logic [WI_W-1:0]     w_end_r, w_end_nxt;
  logic [OFF_W-1:0]    off_lo_r, off_lo_nxt;
  logic [OFF_W-1:0]    off_hi_r, off_hi_nxt;
  logic                first_r, first_nxt;
  logic [WI_W-1:0]     clr_r, clr_nxt;
  logic                res_valid_r, res_valid_nxt;
  logic [BLK_W-1:0]    res_block_r, res_block_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;

  logic [VW-1:0]       tot_c, ms_c, ds_c, tb_ext, ms_ext, ds_ext;
  logic [VW-1:0]       div_in, div_q;
  logic [OFF_W-1:0]    div_r;
  logic                rd_en, wr_en;
  logic [WI_W-1:0]     rd_addr, wr_addr;
  logic [WORD_BITS-1:0] rd_data, wr_data, free_v;
  logic                hit;
  logic [OFF_W-1:0]    idx;
  logic [VW-1:0]       grant_sum;

  rbba_cdiv #(.VW(VW), .DIVISOR(WORD_BITS), .OFF_W(OFF_W)) u_div (
    .clk (clk),
    .din (div_in),
    .quo (div_q),
    .rem (div_r)
  );

  rbba_map #(.WORDS(MAP_WORDS), .WB(WORD_BITS), .AW(WI_W)) u_map (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_comb begin
    tb_ext = VW'(cfg.total_blocks);
    ms_ext = VW'(cfg.meta_start);
    ds_ext = VW'(cfg.data_base);
    tot_c  = (tb_ext > NB_V) ? NB_V : tb_ext;
    ms_c   = (ms_ext > tot_c) ? tot_c : ms_ext;
    ds_c   = (ds_ext > tot_c) ? tot_c : ds_ext;
  end

  // free bits of the current word inside the region, lowest first
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      free_v[i] = !rd_data[i]
                  && (!first_r || OFF_W'(i) >= off_lo_r)
                  && (w_r != w_end_r || OFF_W'(i) <= off_hi_r);
    end
    hit = 1'b0;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_v[i]) begin
        hit = 1'b1;
        idx = OFF_W'(i);
      end
    end
    grant_sum = base_r + VW'(idx);
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    bno_nxt        = bno_r;
    tot_nxt        = tot_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    base_nxt       = base_r;
    w_nxt          = w_r;
    w_end_nxt      = w_end_r;
    off_lo_nxt     = off_lo_r;
    off_hi_nxt     = off_hi_r;
    first_nxt      = first_r;
    clr_nxt        = clr_r;
    res_valid_nxt  = 1'b0;
    res_block_nxt  = res_block_r;
    res_status_nxt = res_status_r;
    div_in         = lo_r;
    rd_en          = 1'b0;
    rd_addr        = w_r;
    wr_en          = 1'b0;
    wr_addr        = w_r;
    wr_data        = rd_data;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_W) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = op;
          bno_nxt   = block_number;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        tot_nxt = tot_c;
        case (op_r)
          OP_ALLOC_META: begin
            lo_nxt = ms_c;
            hi_nxt = ds_c;
          end
          OP_ALLOC_DATA: begin
            lo_nxt = ds_c;
            hi_nxt = tot_c;
          end
          default: begin
            lo_nxt = '0;
            hi_nxt = tot_c;
          end
        endcase
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        div_in    = (op_r == OP_FREE) ? VW'(bno_r) : lo_r;
        state_nxt = S_DIV2;
        if (op_r == OP_FREE) begin
          if (VW'(bno_r) >= tot_r) begin
            res_valid_nxt  = 1'b1;
            res_block_nxt  = '0;
            res_status_nxt = ST_RANGE;
            state_nxt      = S_IDLE;
          end
        end else if (lo_r >= hi_r) begin
          res_valid_nxt  = 1'b1;
          res_block_nxt  = '0;
          res_status_nxt = ST_NO_FREE;
          state_nxt      = S_IDLE;
        end
      end
      S_DIV2: begin
        div_in    = hi_r - 1'b1;
        state_nxt = S_DIV3;
      end
      S_DIV3: begin
        w_nxt      = div_q[WI_W-1:0];
        off_lo_nxt = div_r;
        base_nxt   = lo_r - VW'(div_r);
        if (op_r == OP_FREE) begin
          rd_en     = 1'b1;
          rd_addr   = div_q[WI_W-1:0];
          state_nxt = S_FREE_WR;
        end else begin
          state_nxt = S_DIV4;
        end
      end
      S_DIV4: begin
        w_end_nxt  = div_q[WI_W-1:0];
        off_hi_nxt = div_r;
        first_nxt  = 1'b1;
        rd_en      = 1'b1;
        rd_addr    = w_r;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          wr_en          = 1'b1;
          wr_data        = rd_data | (WORD_BITS'(1) << idx);
          res_valid_nxt  = 1'b1;
          res_block_nxt  = grant_sum[BLK_W-1:0];
          res_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end else if (w_r == w_end_r) begin
          res_valid_nxt  = 1'b1;
          res_block_nxt  = '0;
          res_status_nxt = ST_NO_FREE;
          state_nxt      = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = w_r + 1'b1;
          w_nxt     = w_r + 1'b1;
          base_nxt  = base_r + WB_V;
          first_nxt = 1'b0;
        end
      end
      S_FREE_WR: begin
        wr_en          = 1'b1;
        wr_data        = rd_data & ~(WORD_BITS'(1) << off_lo_r);
        res_valid_nxt  = 1'b1;
        res_block_nxt  = '0;
        res_status_nxt = ST_OK;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    bno_r        <= bno_nxt;
    tot_r        <= tot_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    base_r       <= base_nxt;
    w_r          <= w_nxt;
    w_end_r      <= w_end_nxt;
    off_lo_r     <= off_lo_nxt;
    off_hi_r     <= off_hi_nxt;
    first_r      <= first_nxt;
    res_block_r  <= res_block_nxt;
    res_status_r <= res_status_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign res_valid  = res_valid_r;
  assign res_block  = res_block_r;
  assign res_status = res_status_r;

endmodule

[bench/rbba_checker.sv]
module rbba_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [rbba_pkg::OP_W-1:0]      in_op,
  input  logic [rbba_pkg::BLK_W-1:0]     in_block_number,
  input  logic                           out_valid,
  input  logic [rbba_pkg::BLK_W-1:0]     out_granted_block,
  input  logic [rbba_pkg::STAT_W-1:0]    out_status,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rbba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbba_pkg::REG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending_count
);

  import rbba_pkg::*;

  typedef struct packed {
    logic [BLK_W-1:0]  blk;
    logic [STAT_W-1:0] stat;
  } grant_t;

  grant_t                    grant_q[$];
  grant_t                    want;
  grant_t                    seen;
  logic [NUM_BLOCKS_DEF-1:0] used_bits;
  logic [REG_W-1:0]          total_r;
  logic [REG_W-1:0]          meta_r;
  logic [REG_W-1:0]          data_r;
  int                        fails = 0;

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic serve(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] bno,
                       output grant_t g);
    int tot;
    int ms;
    int ds;
    int lo;
    int hi;
    int b;
    bit found;
    tot = (int'(total_r) > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : int'(total_r);
    ms  = (int'(meta_r) > tot) ? tot : int'(meta_r);
    ds  = (int'(data_r) > tot) ? tot : int'(data_r);
    g.blk  = '0;
    g.stat = ST_OK;
    if (op == OP_FREE) begin
      if (int'(bno) < tot) used_bits[bno] = 1'b0;
      else g.stat = ST_RANGE;
    end else begin
      case (op)
        OP_ALLOC_META: begin
          lo = ms;
          hi = ds;
        end
        OP_ALLOC_DATA: begin
          lo = ds;
          hi = tot;
        end
        default: begin
          lo = 0;
          hi = tot;
        end
      endcase
      found = 1'b0;
      b = lo;
      while (!found && b < hi) begin
        if (!used_bits[b[BLK_W-1:0]]) begin
          used_bits[b[BLK_W-1:0]] = 1'b1;
          g.blk = b[BLK_W-1:0];
          found = 1'b1;
        end
        b++;
      end
      if (!found) g.stat = ST_NO_FREE;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      used_bits = '0;
      total_r   = TOTAL_BLOCKS_RST;
      meta_r    = META_START_RST;
      data_r    = DATA_BASE_RST;
      grant_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOTAL_BLOCKS: total_r = cfg_data;
          CFG_META_START:   meta_r  = cfg_data;
          CFG_DATA_BASE:    data_r  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        seen.blk  = out_granted_block;
        seen.stat = out_status;
        if (grant_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, actual block %0d status %0d",
                   $time, seen.blk, seen.stat);
        end else begin
          want = grant_q.pop_front();
          if (seen.blk !== want.blk) begin
            fails++;
            $display("%0t: granted_block mismatch: expected %0d, actual %0d",
                     $time, want.blk, seen.blk);
          end
          if (seen.stat !== want.stat) begin
            fails++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.stat, seen.stat);
          end
        end
      end
      if (start && !busy) begin
        serve(in_op, in_block_number, want);
        grant_q.push_back(want);
      end
    end
    fail_count    <= fails;
    pending_count <= grant_q.size();
  end

endmodule

[bench/tb_region_bitmap_block_allocator.sv]
module tb_region_bitmap_block_allocator;
  import rbba_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int NUM_PHASES   = 14;
  localparam int PHASE_ITEMS  = 100;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [OP_W-1:0]      in_op;
  logic [BLK_W-1:0]     in_block_number;
  logic                 out_valid;
  logic [BLK_W-1:0]     out_granted_block;
  logic [STAT_W-1:0]    out_status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0]     cfg_data;

  int fail_count;
  int pending_count;
  int cycles = 0;
  int cur_total;

  region_bitmap_block_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_block_number   (in_block_number),
    .out_valid         (out_valid),
    .out_granted_block (out_granted_block),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  rbba_checker u_grant_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_block_number   (in_block_number),
    .out_valid         (out_valid),
    .out_granted_block (out_granted_block),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 100);
  endfunction

  function automatic logic [BLK_W-1:0] any_blk();
    return BLK_W'($urandom_range(0, 4095));
  endfunction

  // hold the item until taken; while idle, junk on the fields
  task automatic send_item(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] bno,
                           input int gap);
    start           <= 1'b1;
    in_op           <= op;
    in_block_number <= bno;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start           <= 1'b0;
      in_op           <= OP_W'($urandom_range(0, 3));
      in_block_number <= any_blk();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TOTAL_BLOCKS) cur_total = int'(val);
    repeat (1 + $urandom_range(0, 3)) @(posedge clk);
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic random_item(input int quiet);
    int r;
    int sat;
    int lim;
    logic [OP_W-1:0]  op;
    logic [BLK_W-1:0] bno;
    r   = $urandom_range(0, 99);
    sat = (cur_total > NUM_BLOCKS_DEF) ? NUM_BLOCKS_DEF : cur_total;
    lim = (sat + 8 > 4095) ? 4095 : sat + 8;
    if (r < 25) op = OP_ALLOC_META;
    else if (r < 50) op = OP_ALLOC_DATA;
    else if (r < 65) op = OP_ALLOC_ANY;
    else op = OP_FREE;
    if (op == OP_FREE && $urandom_range(0, 9) < 7) bno = BLK_W'($urandom_range(0, lim));
    else bno = any_blk();
    send_item(op, bno, quiet ? 0 : pick_gap());
  endtask

  task automatic set_config(input int kind);
    int t;
    int m;
    int d;
    case (kind)
      0: begin
        t = $urandom_range(1, 300);
        m = $urandom_range(0, t);
        d = $urandom_range(m, t);
      end
      1: begin
        t = $urandom_range(0, 8191);
        m = $urandom_range(0, 8191);
        d = $urandom_range(0, 8191);
      end
      2: begin
        t = 4096;
        m = 0;
        d = $urandom_range(4032, 4096);
      end
      3: begin
        t = 0;
        m = 0;
        d = 0;
      end
      4: begin
        t = 8191;
        m = $urandom_range(0, 64);
        d = 8191;
      end
      default: begin
        t = 64;
        m = 0;
        d = 32;
      end
    endcase
    if ($urandom_range(0, 1)) write_reg(CFG_TOTAL_BLOCKS, REG_W'(t));
    write_reg(CFG_DATA_BASE, REG_W'(d));
    write_reg(CFG_META_START, REG_W'(m));
    if (cur_total != t) write_reg(CFG_TOTAL_BLOCKS, REG_W'(t));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, REG_W'($urandom_range(0, 8191)));
  endtask

  initial begin
    int kind;
    int r;
    int quiet;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_op           = OP_ALLOC_META;
    in_block_number = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_TOTAL_BLOCKS;
    cfg_data        = '0;
    cur_total       = int'(TOTAL_BLOCKS_RST);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: 2048 blocks, metadata from 2, data from 1024
    send_item(OP_ALLOC_META, any_blk(), pick_gap());
    send_item(OP_ALLOC_DATA, any_blk(), pick_gap());
    send_item(OP_ALLOC_ANY, any_blk(), pick_gap());
    send_item(OP_ALLOC_ANY, any_blk(), pick_gap());
    send_item(OP_ALLOC_ANY, 12'hfff, pick_gap());
    send_item(OP_FREE, 12'd2, pick_gap());
    send_item(OP_FREE, 12'd2, pick_gap());
    send_item(OP_FREE, 12'd2047, pick_gap());
    send_item(OP_FREE, 12'd2048, pick_gap());
    send_item(OP_FREE, 12'hfff, pick_gap());
    send_item(OP_ALLOC_META, 12'd0, pick_gap());
    settle();
    // empty metadata region
    write_reg(CFG_META_START, 13'd500);
    write_reg(CFG_DATA_BASE, 13'd500);
    send_item(OP_ALLOC_META, any_blk(), pick_gap());
    settle();
    // inverted region
    write_reg(CFG_META_START, 13'd600);
    write_reg(CFG_DATA_BASE, 13'd100);
    send_item(OP_ALLOC_META, any_blk(), pick_gap());
    send_item(OP_ALLOC_DATA, any_blk(), pick_gap());
    settle();
    // no blocks at all
    write_reg(CFG_TOTAL_BLOCKS, 13'd0);
    send_item(OP_ALLOC_ANY, any_blk(), pick_gap());
    send_item(OP_FREE, 12'd0, pick_gap());
    send_item(OP_ALLOC_DATA, any_blk(), pick_gap());
    settle();
    // saturated bounds, data region is the last block
    write_reg(CFG_TOTAL_BLOCKS, 13'h1fff);
    write_reg(CFG_META_START, 13'h1fff);
    write_reg(CFG_DATA_BASE, 13'd4095);
    write_reg(CFG_SPARE, 13'h1fff);
    send_item(OP_ALLOC_DATA, any_blk(), pick_gap());
    send_item(OP_ALLOC_DATA, any_blk(), pick_gap());
    send_item(OP_ALLOC_META, any_blk(), pick_gap());
    send_item(OP_FREE, 12'hfff, pick_gap());
    send_item(OP_ALLOC_DATA, any_blk(), pick_gap());
    send_item(OP_ALLOC_ANY, any_blk(), pick_gap());

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      if (p < 4) begin
        kind = p + 2;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) kind = 0;
        else if (r < 60) kind = 1;
        else if (r < 70) kind = 2;
        else if (r < 75) kind = 3;
        else if (r < 85) kind = 4;
        else kind = 5;
      end
      set_config(kind);
      quiet = int'($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) random_item(quiet);
    end

    settle();
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
